// File: hw/rtl/iqring_pkg.sv
// ----------------------------------------------------------------------------
// iqring_pkg
// shared constants, operation codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package iqring_pkg;

    // ring storage
    localparam int DEPTH      = 4096;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CFG_W      = IDX_W + 1;
    localparam int SAMPLE_W   = 32;
    localparam int PAIR_W     = 2 * SAMPLE_W;
    localparam int CNT_W      = 32;
    localparam int FILL_W     = 12;
    localparam int MIN_RING   = 4;

    // stream packing
    localparam int S_DATA_W   = PAIR_W;
    localparam int M_FIELDS_W = PAIR_W + FILL_W + 3 * CNT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_USER_W   = 2;

    // ring size limits as register-width values
    localparam logic [CFG_W-1:0] RING_MIN = CFG_W'(MIN_RING);
    localparam logic [CFG_W-1:0] RING_MAX = CFG_W'(DEPTH);

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take;      // input beat accepted this cycle
        logic is_read;   // accepted beat is a read
        logic capture;   // store read data is valid this cycle
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             out_valid;
        logic             empty;
        logic [IDX_W-1:0] cap_m1;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/iq_sample_ring_drop_oldest.sv
// ----------------------------------------------------------------------------
// iq_sample_ring_drop_oldest
// ring of i/q sample pairs that drops the oldest pair when full
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata {q_sample, i_sample}, s_tuser op
//  m_        out        m_tvalid/m_tready    m_tdata totals/fill/pair, m_tuser flags
//  cfg_      in         cfg_valid/cfg_ready  cfg_data ring_size
//
//  a write beat and a read of an empty ring go straight to the result register;
//  a read of a held pair first passes the registered read port of the sample store
//  reset clears indices, fill count and totals; the sample store is not cleared
//  and ring size returns to the full depth, with no clearing pass
//  a new beat is taken in the cycle its predecessor's result drains, so a
//  stalled m_ side holds off s_ after one pending result
//  ring_size writes empty the ring and are taken at once (cfg_ready stays high)
//
`default_nettype none

module iq_sample_ring_drop_oldest (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // input beats
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [iqring_pkg::S_DATA_W-1:0]      s_tdata,  // i_sample, q_sample
    input  wire logic                                 s_tuser,  // op

    // result beats
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // i_out, q_out, fill_level, overflow_total, written_total, consumed_total, zero pad
    output logic      [iqring_pkg::M_DATA_W-1:0]      m_tdata,
    output logic      [iqring_pkg::M_USER_W-1:0]      m_tuser,  // data_valid, dropped_oldest

    // ring size register
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [iqring_pkg::CFG_W-1:0]         cfg_data
);

    iqring_pkg::ctrl_cmd_t  cmd;
    iqring_pkg::dp_status_t status;

    // the user must write the register only while idle (the block does not enforce it), so it never has to wait
    assign cfg_ready = 1'b1;

    // sequencing of beats and the store read latency
    iqring_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // indices, fill, totals, store and result register
    iqring_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a pending result is never overwritten by a newly taken beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("input beat taken over a pending result");

    // a read result never reports a dropped pair
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
        else $error("read result flagged as drop");

    // a result without a pair carries zero sample words
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[2*iqring_pkg::SAMPLE_W-1:0] == '0))
        else $error("sample words not zero without a pair");

    // fill level stays within the active ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*iqring_pkg::SAMPLE_W +: iqring_pkg::IDX_W] <= status.cap_m1))
        else $error("fill level beyond ring size");

endmodule

`default_nettype wire

// File: hw/rtl/iqring_ram.sv
// ----------------------------------------------------------------------------
// iqring_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module iqring_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/iqring_ctrl.sv
// ----------------------------------------------------------------------------
// iqring_ctrl
// sequencing of input beats: writes taken in idle, and a read-wait state for store reads
// ----------------------------------------------------------------------------
`default_nettype none

module iqring_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   op,
    input  wire logic                   m_tready,
    input  wire iqring_pkg::dp_status_t status,
    output logic                        s_tready,
    output iqring_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_RDWAIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // idle, and the output slot is free or drains at this edge
    assign s_tready = (state_reg == ST_IDLE) && (!status.out_valid || m_tready);

    always_comb begin
        cmd.take    = s_tvalid && s_tready;
        cmd.is_read = (op == iqring_pkg::OP_READ);
        cmd.capture = (state_reg == ST_RDWAIT);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.take && cmd.is_read && !status.empty) begin
                    state_next = ST_RDWAIT;
                end
            end
            ST_RDWAIT: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/iqring_dp.sv
// ----------------------------------------------------------------------------
// iqring_dp
// ring indices, fill count, totals, sample store and result register
// ----------------------------------------------------------------------------
`default_nettype none

module iqring_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire iqring_pkg::ctrl_cmd_t                 cmd,
    input  wire logic [iqring_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire logic                                  m_tready,
    input  wire logic                                  cfg_valid,
    input  wire logic [iqring_pkg::CFG_W-1:0]          cfg_data,
    output iqring_pkg::dp_status_t                     status,
    output logic                                       m_tvalid,
    output logic      [iqring_pkg::M_DATA_W-1:0]       m_tdata,
    output logic      [iqring_pkg::M_USER_W-1:0]       m_tuser
);

    localparam int IW = iqring_pkg::IDX_W;
    localparam int SW = iqring_pkg::SAMPLE_W;
    localparam int CW = iqring_pkg::CNT_W;

    logic [IW-1:0] wr_idx_reg,  wr_idx_next;
    logic [IW-1:0] rd_idx_reg,  rd_idx_next;
    logic [IW-1:0] fill_reg,    fill_next;
    logic [IW-1:0] cap_m1_reg,  cap_m1_next;
    logic [CW-1:0] ovf_cnt_reg, ovf_cnt_next;
    logic [CW-1:0] wr_cnt_reg,  wr_cnt_next;
    logic [CW-1:0] rd_cnt_reg,  rd_cnt_next;
    logic          out_vld_reg, out_vld_next;

    // result payload
    logic          dvalid_reg,  dvalid_next;
    logic          dropped_reg, dropped_next;
    logic [SW-1:0] i_out_reg,   i_out_next;
    logic [SW-1:0] q_out_reg,   q_out_next;

    logic                            do_write;
    logic                            do_read;
    logic                            full;
    logic                            empty;
    logic [iqring_pkg::CFG_W-1:0]    cap_clamped;
    logic [iqring_pkg::PAIR_W-1:0]   ram_rdata;
    logic [IW-1:0]                   wr_idx_inc;
    logic [IW-1:0]                   rd_idx_inc;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == cap_m1_reg);
    assign do_write = cmd.take && !cmd.is_read;
    assign do_read  = cmd.take && cmd.is_read && !empty;

    assign wr_idx_inc = (wr_idx_reg == cap_m1_reg) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == cap_m1_reg) ? '0 : rd_idx_reg + 1'b1;

    always_comb begin
        if (cfg_data < iqring_pkg::RING_MIN) begin
            cap_clamped = iqring_pkg::RING_MIN;
        end else if (cfg_data > iqring_pkg::RING_MAX) begin
            cap_clamped = iqring_pkg::RING_MAX;
        end else begin
            cap_clamped = cfg_data;
        end
    end

    always_comb begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        fill_next    = fill_reg;
        cap_m1_next  = cap_m1_reg;
        ovf_cnt_next = ovf_cnt_reg;
        wr_cnt_next  = wr_cnt_reg;
        rd_cnt_next  = rd_cnt_reg;

        if (cfg_valid) begin
            // resizing empties the ring
            cap_m1_next = IW'(cap_clamped - 1'b1);
            wr_idx_next = '0;
            rd_idx_next = '0;
            fill_next   = '0;
        end else if (do_write) begin
            wr_idx_next = wr_idx_inc;
            wr_cnt_next = wr_cnt_reg + 1'b1;
            if (full) begin
                rd_idx_next  = rd_idx_inc;
                ovf_cnt_next = ovf_cnt_reg + 1'b1;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end else if (do_read) begin
            rd_idx_next = rd_idx_inc;
            rd_cnt_next = rd_cnt_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end
        if (cmd.capture || (cmd.take && !do_read)) begin
            out_vld_next = 1'b1;
        end

        dvalid_next  = dvalid_reg;
        dropped_next = dropped_reg;
        i_out_next   = i_out_reg;
        q_out_next   = q_out_reg;
        if (cmd.take) begin
            dvalid_next  = 1'b0;
            dropped_next = do_write && full;
            i_out_next   = '0;
            q_out_next   = '0;
        end else if (cmd.capture) begin
            dvalid_next = 1'b1;
            i_out_next  = ram_rdata[SW-1:0];
            q_out_next  = ram_rdata[2*SW-1:SW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            fill_reg    <= '0;
            cap_m1_reg  <= IW'(iqring_pkg::DEPTH - 1);
            ovf_cnt_reg <= '0;
            wr_cnt_reg  <= '0;
            rd_cnt_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            fill_reg    <= fill_next;
            cap_m1_reg  <= cap_m1_next;
            ovf_cnt_reg <= ovf_cnt_next;
            wr_cnt_reg  <= wr_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvalid_reg  <= dvalid_next;
        dropped_reg <= dropped_next;
        i_out_reg   <= i_out_next;
        q_out_reg   <= q_out_next;
    end

    // pair stored as {q, i}, matching the input beat layout
    iqring_ram #(
        .WIDTH (iqring_pkg::PAIR_W),
        .DEPTH (iqring_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (wr_idx_reg),
        .wdata (s_tdata),
        .re    (do_read),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // totals and fill stay put while a result waits, so they drive the port directly
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = {dropped_reg, dvalid_reg};
    assign m_tdata  = iqring_pkg::M_DATA_W'({rd_cnt_reg, wr_cnt_reg, ovf_cnt_reg,
                                             iqring_pkg::FILL_W'(fill_reg),
                                             q_out_reg, i_out_reg});

    always_comb begin
        status.out_valid = out_vld_reg;
        status.empty     = empty;
        status.cap_m1    = cap_m1_reg;
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the i/q sample ring that drops the oldest pair
// random and directed read/write beats against a ring predictor, with random
// back-pressure on both streams, several ring sizes including the clamped ones
// ----------------------------------------------------------------------------

module tb;
    import iqring_pkg::*;

    // field offsets inside m_tdata, lowest field first
    localparam int I_LO   = 0;
    localparam int Q_LO   = SAMPLE_W;
    localparam int FILL_LO = PAIR_W;
    localparam int OVF_LO = FILL_LO + FILL_W;
    localparam int WR_LO  = OVF_LO + CNT_W;
    localparam int RD_LO  = WR_LO + CNT_W;

    localparam int N_PHASES   = 11;
    localparam int PHASE_BEATS = 140;
    localparam int HOLD_CYCLES = 120;

    typedef struct {
        logic                data_valid;
        logic [SAMPLE_W-1:0] i_out;
        logic [SAMPLE_W-1:0] q_out;
        logic                dropped;
        logic [FILL_W-1:0]   fill;
        logic [CNT_W-1:0]    overflow_total;
        logic [CNT_W-1:0]    written_total;
        logic [CNT_W-1:0]    consumed_total;
    } ring_result_t;

    // ring predictor plus the queue of results it still owes
    class ring_scoreboard;
        bit [PAIR_W-1:0]  pair_store [DEPTH];
        int unsigned      wr_idx;
        int unsigned      rd_idx;
        bit [CNT_W-1:0]   overflow_cnt;
        bit [CNT_W-1:0]   written_cnt;
        bit [CNT_W-1:0]   consumed_cnt;
        bit [CFG_W-1:0]   ring_size = RING_MAX;
        ring_result_t     owed_q [$];
        int unsigned      mismatches;

        function int unsigned pending();
            return owed_q.size();
        endfunction

        task log_mismatch(string msg);
            mismatches++;
            $display("mismatch @%0t: %s", $realtime, msg);
        endtask

        // out-of-range sizes clamp to the legal span
        function int unsigned slots();
            int unsigned n;
            n = ring_size;
            if (n < MIN_RING) n = MIN_RING;
            if (n > DEPTH) n = DEPTH;
            return n;
        endfunction

        function int unsigned held(int unsigned cap);
            return (wr_idx >= rd_idx) ? wr_idx - rd_idx : wr_idx + cap - rd_idx;
        endfunction

        // a size write empties the ring, counters and store are kept
        function void set_ring_size(bit [CFG_W-1:0] size);
            ring_size = size;
            wr_idx = 0;
            rd_idx = 0;
        endfunction

        function void note_beat(logic op, logic [SAMPLE_W-1:0] i_s, logic [SAMPLE_W-1:0] q_s);
            ring_result_t r;
            int unsigned  cap;
            int unsigned  nxt;
            cap = slots();
            r.data_valid = 1'b0;
            r.i_out      = '0;
            r.q_out      = '0;
            r.dropped    = 1'b0;
            if (wr_idx >= cap) wr_idx = 0;
            if (rd_idx >= cap) rd_idx = 0;
            if (op == OP_WRITE) begin
                nxt = (wr_idx + 1 >= cap) ? 0 : wr_idx + 1;
                // full ring: step past the oldest pair first
                if (nxt == rd_idx) begin
                    rd_idx = (rd_idx + 1 >= cap) ? 0 : rd_idx + 1;
                    overflow_cnt++;
                    r.dropped = 1'b1;
                end
                pair_store[wr_idx] = {i_s, q_s};
                wr_idx = nxt;
                written_cnt++;
            end else if (held(cap) != 0) begin
                r.data_valid = 1'b1;
                {r.i_out, r.q_out} = pair_store[rd_idx];
                rd_idx = (rd_idx + 1 >= cap) ? 0 : rd_idx + 1;
                consumed_cnt++;
            end
            r.fill           = FILL_W'(held(cap));
            r.overflow_total = overflow_cnt;
            r.written_total  = written_cnt;
            r.consumed_total = consumed_cnt;
            owed_q.push_back(r);
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                log_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_beat(logic [M_DATA_W-1:0] tdata, logic [M_USER_W-1:0] tuser);
            ring_result_t want;
            if (owed_q.size() == 0) begin
                log_mismatch("result beat with nothing pending");
                return;
            end
            want = owed_q.pop_front();
            compare_field("data_valid", 32'(tuser[0]), 32'(want.data_valid));
            compare_field("dropped_oldest", 32'(tuser[1]), 32'(want.dropped));
            compare_field("i_out", tdata[I_LO +: SAMPLE_W], want.i_out);
            compare_field("q_out", tdata[Q_LO +: SAMPLE_W], want.q_out);
            compare_field("fill_level", 32'(tdata[FILL_LO +: FILL_W]), 32'(want.fill));
            compare_field("overflow_total", tdata[OVF_LO +: CNT_W], want.overflow_total);
            compare_field("written_total", tdata[WR_LO +: CNT_W], want.written_total);
            compare_field("consumed_total", tdata[RD_LO +: CNT_W], want.consumed_total);
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;  // i_sample, q_sample
    logic                  s_tuser   = OP_WRITE;  // op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // i_out, q_out, fill_level, overflow_total, written_total, consumed_total, pad
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;  // data_valid, dropped_oldest
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // idle odds in percent, set per phase by the stimulus process
    int unsigned tx_idle_pct = 27;
    int unsigned rx_idle_pct = 82;

    // long receiver hold-off, counted by the sink process itself
    bit          rx_hold_req  = 1'b0;
    int unsigned rx_hold_left = 0;

    ring_scoreboard sb = new();

    iq_sample_ring_drop_oldest dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result sink: random back-pressure, or a long hold when asked for one
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every handshake is seen here at the edge where it happens
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_ring_size(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser, s_tdata[I_LO +: SAMPLE_W], s_tdata[Q_LO +: SAMPLE_W]);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser);
        end
    end

    // offer one beat, after random idle cycles, and wait until it is taken
    task automatic push_beat(input logic op, input logic [SAMPLE_W-1:0] i_s,
                             input logic [SAMPLE_W-1:0] q_s);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {q_s, i_s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic push_read();
        push_beat(OP_READ, $urandom, $urandom);
    endtask

    // stop offering and let every owed result come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // ring size is only changed with the block idle
    task automatic load_ring_size(input logic [CFG_W-1:0] size);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] sizes [N_PHASES];
        int unsigned      wr_pct;
        logic             op;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size (full depth): empty read, extreme words, read back
        push_read();
        push_beat(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
        push_beat(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
        push_read();
        push_read();
        push_read();

        // smallest ring: fill to three pairs, then two writes drop the oldest
        load_ring_size(RING_MIN);
        push_beat(OP_WRITE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        push_beat(OP_WRITE, 32'h0000_0001, 32'h8000_0000);
        push_beat(OP_WRITE, 32'h8000_0000, 32'h0000_0001);
        push_beat(OP_WRITE, 32'h1234_5678, 32'h9ABC_DEF0);
        push_beat(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_read();
        push_read();
        push_read();
        push_read();

        // size zero clamps to the minimum; leave pairs held for the next write
        load_ring_size('0);
        repeat (4) push_beat(OP_WRITE, $urandom, $urandom);
        push_read();

        // size write empties the ring even with pairs held
        load_ring_size(CFG_W'(3));
        push_read();
        push_beat(OP_WRITE, $urandom, $urandom);
        push_read();

        sizes[0]  = CFG_W'(5);
        sizes[1]  = '1;                 // above depth, clamps to depth
        sizes[2]  = CFG_W'($urandom_range(40, 6));
        sizes[3]  = CFG_W'(4);
        sizes[4]  = CFG_W'(2);
        sizes[5]  = CFG_W'($urandom_range(64, 4));
        sizes[6]  = RING_MAX;
        sizes[7]  = CFG_W'($urandom_range(600, 100));
        sizes[8]  = CFG_W'(7);
        sizes[9]  = CFG_W'(DEPTH - 1);
        sizes[10] = CFG_W'($urandom_range(32, 4));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph * 3 / N_PHASES)
                0: begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 82;
                end
                1: begin
                    tx_idle_pct = 82;
                    rx_idle_pct = 27;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            load_ring_size(sizes[ph]);
            // write-heavy phases overflow, read-heavy ones run empty
            wr_pct = $urandom_range(80, 25);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // receiver stalls while the sender keeps offering
                if (ph == 2 && n == 40)
                    rx_hold_req = 1'b1;
                // sender stops until nothing is owed
                if (ph == 5 && n == 70)
                    wait_for_results();
                op = ($urandom_range(99) < wr_pct) ? OP_WRITE : OP_READ;
                push_beat(op, $urandom, $urandom);
            end
        end

        wait_for_results();
        repeat (16) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("timeout with %0d results pending", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
